// ===== design/clfk_pkg.sv =====
// ----------------------------------------------------------------------------
// clfk_pkg: shared types and constants of the crlf line framer
// Frame state encoding, status codes, beat payload types and the keyword
// match used by the framing core.
// ----------------------------------------------------------------------------
package clfk_pkg;

   // default longest line before overflow
   localparam int MAX_LINE_DEF = 255;

   // opcode values
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // status codes
   localparam logic [2:0] ST_STORED   = 3'd0;
   localparam logic [2:0] ST_COMPLETE = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_HELD     = 3'd3;
   localparam logic [2:0] ST_RELEASED = 3'd4;

   // frame state codes as seen on the result port
   localparam logic [1:0] FS_FREE     = 2'd0;
   localparam logic [1:0] FS_RUNNING  = 2'd1;
   localparam logic [1:0] FS_FINISHED = 2'd2;
   localparam logic [1:0] FS_ERROR    = 2'd3;

   // special bytes
   localparam logic [7:0] BYTE_NUL = 8'h00;
   localparam logic [7:0] BYTE_LF  = 8'h0A;
   localparam logic [7:0] BYTE_CR  = 8'h0D;

   // keyword patterns, newest byte in the low position
   localparam logic [15:0] KW_OK        = 16'h4F4B;
   localparam logic [31:0] KW_BUSY      = 32'h62757379;
   localparam logic [23:0] KW_HASH_CRLF = 24'h230D0A;
   localparam logic [31:0] KW_ERRO      = 32'h4552524F;
   localparam logic [7:0]  KW_ERR_LAST  = 8'h52;

   // frame state machine, one-hot
   typedef enum logic [3:0] {
      FR_FREE    = 4'b0001,
      FR_RUNNING = 4'b0010,
      FR_DONE    = 4'b0100,
      FR_ERROR   = 4'b1000
   } frame_type;

   // input beat
   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } item_type;

   // result beat
   typedef struct packed {
      logic [2:0] status;
      logic [7:0] echo_byte;
      logic [7:0] position;
      logic [1:0] frame_state_out;
   } result_type;

   // true when the new byte closes one of the response keywords
   function automatic logic keyword_ends_here(input logic [31:0] older,
                                              input logic [7:0]  b);
      logic [31:0] w;
      w = {older[23:0], b};
      keyword_ends_here = (w[15:0] == KW_OK) || (w == KW_BUSY) ||
                          (w[23:0] == KW_HASH_CRLF) ||
                          ((older == KW_ERRO) && (b == KW_ERR_LAST));
   endfunction

   // port code of a frame state
   function automatic logic [1:0] frame_code(input frame_type fs);
      logic [1:0] code;
      unique case (fs)
         FR_FREE:    code = FS_FREE;
         FR_RUNNING: code = FS_RUNNING;
         FR_DONE:    code = FS_FINISHED;
         FR_ERROR:   code = FS_ERROR;
         default:    code = FS_FREE;
      endcase
      frame_code = code;
   endfunction

endpackage

// ===== design/clfk_in_stage.sv =====
// ----------------------------------------------------------------------------
// clfk_in_stage: input register
// Captures one request beat and holds it until the core takes it.
// ----------------------------------------------------------------------------
module clfk_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  clfk_pkg::item_type  req_item,
   input  logic                take,
   output logic                item_valid,
   output clfk_pkg::item_type  item
);

   logic               valid_ff;
   logic               valid_in;
   clfk_pkg::item_type item_ff;

   // free when empty or when the held beat moves on this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload load
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== design/clfk_frame_core.sv =====
// ----------------------------------------------------------------------------
// clfk_frame_core: line framing state and per-beat result
// Keeps the frame state, line count, last four bytes and keyword flags and
// works out one result for each beat combinationally.
// ----------------------------------------------------------------------------
module clfk_frame_core #(
   parameter int MAX_LINE = clfk_pkg::MAX_LINE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_keyword_mode,
   input  logic                  step,
   input  clfk_pkg::item_type    item,
   output clfk_pkg::result_type  result
);

   localparam int CNT_W = $clog2(MAX_LINE + 1);

   logic                 keyword_mode_ff;
   clfk_pkg::frame_type  frame_ff, frame_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [31:0]          recent_ff, recent_in;
   logic                 kw_seen_ff, kw_seen_in;
   logic                 zero_seen_ff, zero_seen_in;

   logic [CNT_W-1:0]     base_count;
   logic [31:0]          base_recent;
   logic                 base_kw;
   logic                 base_zero;
   logic [CNT_W:0]       count_inc;
   logic                 kw_new;
   logic                 zero_new;
   logic                 line_done;
   logic                 is_free;

   // line as seen by a stored byte: cleared when the frame is free
   assign is_free     = (frame_ff == clfk_pkg::FR_FREE);
   assign base_count  = is_free ? '0 : count_ff;
   assign base_recent = is_free ? '0 : recent_ff;
   assign base_kw     = is_free ? 1'b0 : kw_seen_ff;
   assign base_zero   = is_free ? 1'b0 : zero_seen_ff;
   assign count_inc   = {1'b0, base_count} + (CNT_W+1)'(1);

   // keyword search stops at the first zero byte
   assign zero_new = base_zero || (item.rx_byte == clfk_pkg::BYTE_NUL);
   assign kw_new   = base_kw || (!base_zero && (item.rx_byte != clfk_pkg::BYTE_NUL) &&
                     clfk_pkg::keyword_ends_here(base_recent, item.rx_byte));

   // cr lf ending a line of at least three bytes, plus keyword in keyword mode
   assign line_done = (count_inc > (CNT_W+1)'(2)) &&
                      (item.rx_byte == clfk_pkg::BYTE_LF) &&
                      (base_recent[7:0] == clfk_pkg::BYTE_CR) &&
                      (!keyword_mode_ff || kw_new);

   // next state and result
   always_comb begin
      frame_in            = frame_ff;
      count_in            = count_ff;
      recent_in           = recent_ff;
      kw_seen_in          = kw_seen_ff;
      zero_seen_in        = zero_seen_ff;
      result.status       = clfk_pkg::ST_RELEASED;
      result.echo_byte    = item.rx_byte;
      result.position     = '0;
      priority if (item.opcode == clfk_pkg::OP_RELEASE) begin
         frame_in         = clfk_pkg::FR_FREE;
         result.echo_byte = '0;
      end else if (count_ff >= CNT_W'(MAX_LINE)) begin
         frame_in      = clfk_pkg::FR_ERROR;
         count_in      = '0;
         recent_in     = '0;
         kw_seen_in    = 1'b0;
         zero_seen_in  = 1'b0;
         result.status = clfk_pkg::ST_OVERFLOW;
      end else if (frame_ff == clfk_pkg::FR_DONE || frame_ff == clfk_pkg::FR_ERROR) begin
         result.status = clfk_pkg::ST_HELD;
      end else begin
         result.position = 8'(base_count);
         if (line_done) begin
            frame_in      = clfk_pkg::FR_DONE;
            count_in      = '0;
            recent_in     = '0;
            kw_seen_in    = 1'b0;
            zero_seen_in  = 1'b0;
            result.status = clfk_pkg::ST_COMPLETE;
         end else begin
            frame_in      = clfk_pkg::FR_RUNNING;
            count_in      = count_inc[CNT_W-1:0];
            recent_in     = {base_recent[23:0], item.rx_byte};
            kw_seen_in    = kw_new;
            zero_seen_in  = zero_new;
            result.status = clfk_pkg::ST_STORED;
         end
      end
      result.frame_state_out = clfk_pkg::frame_code(frame_in);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keyword_mode_ff <= 1'b0;
         frame_ff        <= clfk_pkg::FR_FREE;
         count_ff        <= '0;
         recent_ff       <= '0;
         kw_seen_ff      <= 1'b0;
         zero_seen_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            keyword_mode_ff <= csr_keyword_mode;
         end
         if (step) begin
            frame_ff     <= frame_in;
            count_ff     <= count_in;
            recent_ff    <= recent_in;
            kw_seen_ff   <= kw_seen_in;
            zero_seen_ff <= zero_seen_in;
         end
      end
   end

endmodule

// ===== design/clfk_out_stage.sv =====
// ----------------------------------------------------------------------------
// clfk_out_stage: result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module clfk_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  clfk_pkg::result_type  result,
   output logic                  can_load,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output clfk_pkg::result_type  rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   clfk_pkg::result_type result_ff;

   // room when empty or when the held beat leaves this cycle
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload load
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== design/crlf_line_framer_with_keywords_top.sv =====
// ----------------------------------------------------------------------------
// crlf_line_framer_with_keywords_top: serial response line framer
// Frames received bytes into CR LF terminated lines, optionally requiring a
// response keyword, and returns one status beat per request beat.
//
//   channel | direction | fields
//   req_    | in        | opcode, rx_byte
//   rsp_    | out       | status, echo_byte, position, frame_state_out
//   csr_    | in        | keyword_mode (write only)
//
// One beat per cycle sustained while rsp_ready is high; an accepted beat is
// loaded into the input register, then through the framing logic into the
// result register, which raises rsp_valid. Reset is synchronous and clears
// all state, keyword_mode to 0.
// A stalled rsp_ side fills the result and input registers, then drops
// req_ready. csr_ready is always high.
// ----------------------------------------------------------------------------
module crlf_line_framer_with_keywords_top #(
   parameter int MAX_LINE = clfk_pkg::MAX_LINE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_echo_byte,
   output logic [7:0] rsp_position,
   output logic [1:0] rsp_frame_state_out,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_keyword_mode
);

   clfk_pkg::item_type   req_item;
   clfk_pkg::item_type   item;
   clfk_pkg::result_type result;
   clfk_pkg::result_type rsp_result;
   logic                 item_valid;
   logic                 can_load;
   logic                 step;

   assign req_item.opcode  = req_opcode;
   assign req_item.rx_byte = req_rx_byte;

   // a beat moves from input register to result register
   assign step      = item_valid && can_load;
   assign csr_ready = 1'b1;

   clfk_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   clfk_frame_core #(
      .MAX_LINE (MAX_LINE)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_valid),
      .csr_keyword_mode (csr_keyword_mode),
      .step             (step),
      .item             (item),
      .result           (result)
   );

   clfk_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .can_load   (can_load),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_status          = rsp_result.status;
   assign rsp_echo_byte       = rsp_result.echo_byte;
   assign rsp_position        = rsp_result.position;
   assign rsp_frame_state_out = rsp_result.frame_state_out;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the crlf line framer
// Drives byte and release beats through the req_ channel, predicts every
// rsp_ beat in an internal model of the framer and compares field by field.
// Runs directed lines in both keyword settings, then random lines, noise and
// overflow-length lines under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 400_000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_opcode = clfk_pkg::OP_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [7:0] rsp_echo_byte;
   logic [7:0] rsp_position;
   logic [1:0] rsp_frame_state_out;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_keyword_mode = 1'b0;

   // beats waiting to be sent and results waiting to arrive
   clfk_pkg::item_type   send_q[$];
   clfk_pkg::result_type expected_results[$];
   int         queued = 0;
   bit         req_taken = 1'b0;

   // idling mix and long receiver hold-off
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         hold_req = 0;
   int         hold_left = 0;

   int         err_count = 0;
   int         cycle_count = 0;

   // framer model state
   logic        kw_required = 1'b0;
   logic [1:0]  line_state = clfk_pkg::FS_FREE;
   int unsigned line_len = 0;
   logic [31:0] line_tail = '0;
   logic        line_has_kw = 1'b0;
   logic        line_has_nul = 1'b0;

   crlf_line_framer_with_keywords_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_echo_byte       (rsp_echo_byte),
      .rsp_position        (rsp_position),
      .rsp_frame_state_out (rsp_frame_state_out),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_keyword_mode    (csr_keyword_mode)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // framer model
   // ------------------------------------------------------------------------
   function automatic void forget_line();
      line_len = 0;
      line_tail = '0;
      line_has_kw = 1'b0;
      line_has_nul = 1'b0;
   endfunction

   // status beat caused by one request beat, advancing the model
   function automatic clfk_pkg::result_type framed_status(input clfk_pkg::item_type it);
      clfk_pkg::result_type r;
      logic [7:0]  prev;
      logic [39:0] hist;
      r = '0;
      if (it.opcode == clfk_pkg::OP_RELEASE) begin
         line_state = clfk_pkg::FS_FREE;
         r.status = clfk_pkg::ST_RELEASED;
      end else begin
         r.echo_byte = it.rx_byte;
         if (line_len >= clfk_pkg::MAX_LINE_DEF) begin
            // byte past the longest line: dropped, error state
            forget_line();
            line_state = clfk_pkg::FS_ERROR;
            r.status = clfk_pkg::ST_OVERFLOW;
         end else begin
            if (line_state == clfk_pkg::FS_FREE)
               forget_line();
            if (line_state == clfk_pkg::FS_FINISHED || line_state == clfk_pkg::FS_ERROR) begin
               r.status = clfk_pkg::ST_HELD;
            end else begin
               prev = line_tail[7:0];
               r.position = line_len[7:0];
               hist = {line_tail, it.rx_byte};
               // keywords only count before the first nul of the line
               if (!line_has_nul) begin
                  if (it.rx_byte == clfk_pkg::BYTE_NUL)
                     line_has_nul = 1'b1;
                  else if (hist[15:0] == "OK" || hist[31:0] == "busy" ||
                           hist[23:0] == "#\r\n" || hist == "ERROR")
                     line_has_kw = 1'b1;
               end
               line_tail = hist[31:0];
               line_len++;
               line_state = clfk_pkg::FS_RUNNING;
               r.status = clfk_pkg::ST_STORED;
               if (line_len > 2 && it.rx_byte == clfk_pkg::BYTE_LF &&
                   prev == clfk_pkg::BYTE_CR && (!kw_required || line_has_kw)) begin
                  line_state = clfk_pkg::FS_FINISHED;
                  r.status = clfk_pkg::ST_COMPLETE;
                  forget_line();
               end
            end
         end
      end
      r.frame_state_out = line_state;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      clfk_pkg::item_type nxt;
      if (!reset && (!req_valid || req_taken)) begin
         if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = send_q.pop_front();
            req_valid <= 1'b1;
            req_opcode <= nxt.opcode;
            req_rx_byte <= nxt.rx_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // receiver ready, with an occasional long hold-off
   always @(negedge clock) begin : drive_rsp_ready
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // monitor
   // ------------------------------------------------------------------------
   task automatic note_failure(input string what);
      if (err_count < 10)
         $display("%0t mismatch: %s", $realtime, what);
      err_count++;
   endtask

   always @(posedge clock) begin : watch_ports
      clfk_pkg::result_type got;
      clfk_pkg::result_type want;
      clfk_pkg::item_type   taken;
      if (!reset) begin
         // result beat against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.echo_byte = rsp_echo_byte;
            got.position = rsp_position;
            got.frame_state_out = rsp_frame_state_out;
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected beat st=%0d echo=%h pos=%0d fs=%0d",
                  got.status, got.echo_byte, got.position, got.frame_state_out));
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.echo_byte !== want.echo_byte ||
                   got.position !== want.position ||
                   got.frame_state_out !== want.frame_state_out)
                  note_failure($sformatf(
                     "exp st=%0d echo=%h pos=%0d fs=%0d, got st=%0d echo=%h pos=%0d fs=%0d",
                     want.status, want.echo_byte, want.position, want.frame_state_out,
                     got.status, got.echo_byte, got.position, got.frame_state_out));
            end
         end
         // request beat: predict its result
         if (req_valid && req_ready) begin
            taken.opcode = req_opcode;
            taken.rx_byte = req_rx_byte;
            expected_results.push_back(framed_status(taken));
            req_taken = 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_item(input logic op, input logic [7:0] b);
      clfk_pkg::item_type it;
      it.opcode = op;
      it.rx_byte = b;
      send_q.push_back(it);
      queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_item(clfk_pkg::OP_BYTE, s[i]);
   endtask

   task automatic push_release();
      push_item(clfk_pkg::OP_RELEASE, 8'($urandom_range(0, 255)));
   endtask

   // mostly printable, sometimes any byte
   function automatic logic [7:0] filler_byte();
      if ($urandom_range(0, 3) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   // line near the length limit, no CR in its body
   task automatic queue_long_line(input bit to_overflow);
      int         body;
      logic [7:0] b;
      body = to_overflow ? clfk_pkg::MAX_LINE_DEF + 1 :
             $urandom_range(clfk_pkg::MAX_LINE_DEF - 5, clfk_pkg::MAX_LINE_DEF + 1);
      repeat (body) begin
         b = 8'($urandom_range(0, 255));
         if (b == clfk_pkg::BYTE_CR)
            b = 8'h20;
         push_item(clfk_pkg::OP_BYTE, b);
      end
      if ($urandom_range(0, 1) == 1)
         push_text("\r\n");
      push_release();
   endtask

   task automatic queue_random_traffic(input int n);
      int    first;
      int    pick;
      int    cnt;
      int    nul_at;
      string kw;
      first = queued;
      while (queued - first < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // response line: filler, keyword, maybe a nul, terminator
            case ($urandom_range(0, 4))
               0: kw = "OK";
               1: kw = "ERROR";
               2: kw = "busy";
               3: kw = "#";
               default: kw = "";
            endcase
            nul_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : -1;
            cnt = $urandom_range(0, 4);
            repeat (cnt) push_item(clfk_pkg::OP_BYTE, filler_byte());
            if (nul_at == 0)
               push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_NUL);
            push_text(kw);
            if (nul_at == 1)
               push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_NUL);
            if (kw != "#") begin
               cnt = $urandom_range(0, 4);
               repeat (cnt) push_item(clfk_pkg::OP_BYTE, filler_byte());
            end
            // terminator, sometimes broken
            case ($urandom_range(0, 7))
               0: begin
                  push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_CR);
                  push_item(clfk_pkg::OP_BYTE, filler_byte());
               end
               1: push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_LF);
               2: push_release();
               default: push_text("\r\n");
            endcase
            // bytes arriving while held
            if ($urandom_range(0, 3) == 0) begin
               cnt = $urandom_range(1, 2);
               repeat (cnt) push_item(clfk_pkg::OP_BYTE, filler_byte());
            end
            if ($urandom_range(0, 7) != 0)
               push_release();
         end else if (pick < 97) begin
            // noise
            cnt = $urandom_range(1, 6);
            repeat (cnt) begin
               if ($urandom_range(0, 3) == 0)
                  push_release();
               else
                  push_item(clfk_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end
         end else begin
            queue_long_line(1'b0);
         end
      end
   endtask

   task automatic wait_drained();
      while (send_q.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // register write, only with nothing in flight
   task automatic write_keyword_mode(input logic mode);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_keyword_mode <= mode;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      kw_required = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, plain CR LF framing
      write_keyword_mode(1'b0);
      push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_NUL);
      push_item(clfk_pkg::OP_BYTE, 8'hFF);
      push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_CR);
      push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_LF);
      push_item(clfk_pkg::OP_BYTE, 8'h41);
      push_item(clfk_pkg::OP_RELEASE, 8'hFF);
      // CR LF alone is too short to complete
      push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_CR);
      push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_LF);
      push_item(clfk_pkg::OP_RELEASE, 8'h00);
      push_item(clfk_pkg::OP_RELEASE, 8'h00);

      // directed, keyword framing
      write_keyword_mode(1'b1);
      push_text("OK\r\n");
      push_release();
      // keyword after a nul does not count
      push_item(clfk_pkg::OP_BYTE, clfk_pkg::BYTE_NUL);
      push_text("OK\r\n");
      push_release();
      push_text("#\r\n");
      push_release();

      // no idling
      write_keyword_mode(1'b1);
      set_idling(0, 0);
      queue_long_line(1'b1);
      queue_random_traffic(350);

      // sender idle
      write_keyword_mode(1'b0);
      set_idling(53, 0);
      queue_random_traffic(350);

      // receiver stalls, with a long hold-off to back up the input
      write_keyword_mode(1'b1);
      set_idling(0, 53);
      hold_req = 200;
      queue_random_traffic(350);

      // both sides idle
      write_keyword_mode(1'b0);
      set_idling(26, 26);
      queue_long_line(1'b1);
      queue_random_traffic(350);

      wait_drained();
      repeat (20) @(negedge clock);
      if (err_count == 0 && expected_results.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
